// ----- design/discovery_tlv_parser_macros.svh -----
// ---------------------------------------------------------------------------
// discovery_tlv_parser_macros
// assertion macros used by the discovery tlv parser
// ---------------------------------------------------------------------------
`ifndef DISCOVERY_TLV_PARSER_MACROS_SVH
`define DISCOVERY_TLV_PARSER_MACROS_SVH

`ifndef SYNTH
`define DTLV_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("dtlv assertion failed");
`define DTLV_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dtlv assertion failed");
`else
`define DTLV_ASSERT(lbl, cond)
`define DTLV_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- design/dtlv_pkg.sv -----
// ---------------------------------------------------------------------------
// dtlv_pkg
// types and constants of the discovery tlv parser
// ---------------------------------------------------------------------------
package dtlv_pkg;

  localparam int BYTE_W   = 8;
  localparam int LEN_W    = 16;
  localparam int NUM_W    = 32;
  localparam int STATUS_W = 2;

  localparam logic [BYTE_W-1:0] VERSION_RST = 8'd1;
  localparam logic [BYTE_W-1:0] KIND_RST    = 8'd0;

  localparam logic REG_VERSION = 1'b0;
  localparam logic REG_KIND    = 1'b1;

  typedef enum logic [2:0] {
    PH_HDR0  = 3'd0,
    PH_HDR1  = 3'd1,
    PH_HDR2  = 3'd2,
    PH_HDR3  = 3'd3,
    PH_TYPE  = 3'd4,
    PH_LENH  = 3'd5,
    PH_LENL  = 3'd6,
    PH_VALUE = 3'd7
  } phase_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_BAD_HEADER = 2'd1,
    ST_TRUNCATED  = 2'd2
  } status_t;

endpackage

// ----- design/discovery_tlv_parser.sv -----
// ---------------------------------------------------------------------------
// discovery_tlv_parser
// checks the 4-byte packet header and walks type/length/value chunks,
// giving one result word per value byte plus end and error reports
// ---------------------------------------------------------------------------
//  channel  | ports                                  | direction
//  ---------+----------------------------------------+----------
//  in       | in_valid in_stall in_data_byte         | input
//           | in_packet_end                          |
//  out      | out_valid out_stall out_chunk_type ... | output
//  cfg      | cfg_wr_en cfg_index cfg_wdata          | input
//
//  one byte word accepted per cycle while in_stall is low; its result, if
//  any, shows on the output register in the next cycle
//  the parse state and the result register are the only pipeline stage
//  in_stall rises only while a result waits and out_stall is high
//  sync active-low reset clears parse state, out_valid; presets cfg registers
// ---------------------------------------------------------------------------
`include "discovery_tlv_parser_macros.svh"

module discovery_tlv_parser (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [dtlv_pkg::BYTE_W-1:0]     in_data_byte,
  input  logic                            in_packet_end,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [dtlv_pkg::BYTE_W-1:0]     out_chunk_type,
  output logic [dtlv_pkg::BYTE_W-1:0]     out_value_byte,
  output logic [dtlv_pkg::LEN_W-1:0]      out_value_offset,
  output logic                            out_chunk_end,
  output logic [dtlv_pkg::NUM_W-1:0]      out_number_value,
  output logic [dtlv_pkg::STATUS_W-1:0]   out_status,
  output logic                            out_packet_done,
  input  logic                            cfg_wr_en,
  input  logic                            cfg_index,
  input  logic [dtlv_pkg::BYTE_W-1:0]     cfg_wdata
);

  logic [dtlv_pkg::BYTE_W-1:0]   expected_version_r;
  logic [dtlv_pkg::BYTE_W-1:0]   expected_kind_r;

  dtlv_pkg::phase_t              phase_r, phase_nxt;
  logic                          discard_r, discard_nxt;
  logic [dtlv_pkg::BYTE_W-1:0]   type_r, type_nxt;
  logic [dtlv_pkg::LEN_W-1:0]    rem_r, rem_nxt;
  logic [dtlv_pkg::LEN_W-1:0]    off_r, off_nxt;
  logic [dtlv_pkg::NUM_W-1:0]    acc_r, acc_nxt;
  logic [dtlv_pkg::BYTE_W-1:0]   lenh_r, lenh_nxt;

  logic                          out_valid_r;
  logic [dtlv_pkg::BYTE_W-1:0]   out_type_r;
  logic [dtlv_pkg::BYTE_W-1:0]   out_val_r;
  logic [dtlv_pkg::LEN_W-1:0]    out_off_r;
  logic                          out_end_r;
  logic [dtlv_pkg::NUM_W-1:0]    out_num_r;
  logic [dtlv_pkg::STATUS_W-1:0] out_status_r;
  logic                          out_done_r;

  logic                          in_acc;
  logic                          last;
  logic                          hdr_bad;
  logic                          done_chunk;
  logic [dtlv_pkg::LEN_W-1:0]    len_full;
  logic [dtlv_pkg::NUM_W-1:0]    acc_shift;

  logic                          emit;
  logic [dtlv_pkg::BYTE_W-1:0]   e_type;
  logic [dtlv_pkg::BYTE_W-1:0]   e_val;
  logic [dtlv_pkg::LEN_W-1:0]    e_off;
  logic                          e_end;
  logic [dtlv_pkg::NUM_W-1:0]    e_num;
  dtlv_pkg::status_t             e_status;

  assign in_stall   = out_valid_r & out_stall;
  assign in_acc     = in_valid & ~in_stall;
  assign last       = in_packet_end;
  assign hdr_bad    = ((phase_r == dtlv_pkg::PH_HDR0) && (in_data_byte != expected_version_r)) ||
                      ((phase_r == dtlv_pkg::PH_HDR1) && (in_data_byte != expected_kind_r));
  assign done_chunk = (rem_r == dtlv_pkg::LEN_W'(1));
  assign len_full   = {lenh_r, in_data_byte};
  assign acc_shift  = {acc_r[dtlv_pkg::NUM_W-dtlv_pkg::BYTE_W-1:0], in_data_byte};

  // next parse state
  always_comb begin
    phase_nxt   = phase_r;
    discard_nxt = discard_r;
    type_nxt    = type_r;
    rem_nxt     = rem_r;
    off_nxt     = off_r;
    acc_nxt     = acc_r;
    lenh_nxt    = lenh_r;
    if (in_acc) begin
      if (!discard_r) begin
        unique case (phase_r)
          dtlv_pkg::PH_HDR0: begin
            if (hdr_bad) discard_nxt = 1'b1;
            else phase_nxt = dtlv_pkg::PH_HDR1;
          end
          dtlv_pkg::PH_HDR1: begin
            if (hdr_bad) discard_nxt = 1'b1;
            else phase_nxt = dtlv_pkg::PH_HDR2;
          end
          dtlv_pkg::PH_HDR2: phase_nxt = dtlv_pkg::PH_HDR3;
          dtlv_pkg::PH_HDR3: phase_nxt = dtlv_pkg::PH_TYPE;
          dtlv_pkg::PH_TYPE: begin
            type_nxt  = in_data_byte;
            phase_nxt = dtlv_pkg::PH_LENH;
          end
          dtlv_pkg::PH_LENH: begin
            lenh_nxt  = in_data_byte;
            phase_nxt = dtlv_pkg::PH_LENL;
          end
          dtlv_pkg::PH_LENL: begin
            rem_nxt   = len_full;
            off_nxt   = '0;
            acc_nxt   = '0;
            phase_nxt = (len_full == '0) ? dtlv_pkg::PH_TYPE : dtlv_pkg::PH_VALUE;
          end
          dtlv_pkg::PH_VALUE: begin
            acc_nxt = acc_shift;
            off_nxt = off_r + dtlv_pkg::LEN_W'(1);
            rem_nxt = rem_r - dtlv_pkg::LEN_W'(1);
            if (done_chunk) phase_nxt = dtlv_pkg::PH_TYPE;
          end
          default: phase_nxt = dtlv_pkg::PH_HDR0;
        endcase
      end
      if (last) begin
        phase_nxt   = dtlv_pkg::PH_HDR0;
        discard_nxt = 1'b0;
        type_nxt    = '0;
        rem_nxt     = '0;
        off_nxt     = '0;
        acc_nxt     = '0;
        lenh_nxt    = '0;
      end
    end
  end

  // result word
  always_comb begin
    emit     = 1'b0;
    e_type   = (phase_r == dtlv_pkg::PH_TYPE) ? in_data_byte : type_r;
    e_val    = '0;
    e_off    = '0;
    e_end    = 1'b0;
    e_num    = '0;
    e_status = dtlv_pkg::ST_OK;
    if (!discard_r) begin
      unique case (phase_r)
        dtlv_pkg::PH_HDR0, dtlv_pkg::PH_HDR1: begin
          if (hdr_bad) begin
            emit     = 1'b1;
            e_status = dtlv_pkg::ST_BAD_HEADER;
          end else if (last) begin
            emit     = 1'b1;
            e_status = dtlv_pkg::ST_TRUNCATED;
          end
        end
        dtlv_pkg::PH_HDR2, dtlv_pkg::PH_TYPE, dtlv_pkg::PH_LENH: begin
          emit     = last;
          e_status = dtlv_pkg::ST_TRUNCATED;
        end
        dtlv_pkg::PH_HDR3: emit = last;
        dtlv_pkg::PH_LENL: begin
          if (len_full == '0) begin
            emit  = 1'b1;
            e_end = 1'b1;
          end else if (last) begin
            emit     = 1'b1;
            e_status = dtlv_pkg::ST_TRUNCATED;
          end
        end
        dtlv_pkg::PH_VALUE: begin
          emit     = 1'b1;
          e_val    = in_data_byte;
          e_off    = off_r;
          e_end    = done_chunk;
          e_num    = acc_shift;
          e_status = (last && !done_chunk) ? dtlv_pkg::ST_TRUNCATED : dtlv_pkg::ST_OK;
        end
        default: emit = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_version_r <= dtlv_pkg::VERSION_RST;
      expected_kind_r    <= dtlv_pkg::KIND_RST;
    end else if (cfg_wr_en) begin
      if (cfg_index == dtlv_pkg::REG_VERSION) expected_version_r <= cfg_wdata;
      if (cfg_index == dtlv_pkg::REG_KIND) expected_kind_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= dtlv_pkg::PH_HDR0;
      discard_r <= 1'b0;
      type_r    <= '0;
      rem_r     <= '0;
      off_r     <= '0;
      acc_r     <= '0;
      lenh_r    <= '0;
    end else begin
      phase_r   <= phase_nxt;
      discard_r <= discard_nxt;
      type_r    <= type_nxt;
      rem_r     <= rem_nxt;
      off_r     <= off_nxt;
      acc_r     <= acc_nxt;
      lenh_r    <= lenh_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!in_stall) begin
      out_valid_r <= in_acc & emit;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && emit) begin
      out_type_r   <= e_type;
      out_val_r    <= e_val;
      out_off_r    <= e_off;
      out_end_r    <= e_end;
      out_num_r    <= e_num;
      out_status_r <= e_status;
      out_done_r   <= last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_chunk_type   = out_type_r;
  assign out_value_byte   = out_val_r;
  assign out_value_offset = out_off_r;
  assign out_chunk_end    = out_end_r;
  assign out_number_value = out_num_r;
  assign out_status       = out_status_r;
  assign out_packet_done  = out_done_r;

  `DTLV_ASSERT_NEXT(a_discard_silent, in_acc && discard_r, !out_valid_r)
  `DTLV_ASSERT_NEXT(a_end_clears, in_acc && in_packet_end,
                    (phase_r == dtlv_pkg::PH_HDR0) && !discard_r && (acc_r == '0))
  `DTLV_ASSERT(a_value_len, (phase_r != dtlv_pkg::PH_VALUE) || (rem_r != '0))
  `DTLV_ASSERT(a_discard_phase,
               !discard_r || (phase_r == dtlv_pkg::PH_HDR0) || (phase_r == dtlv_pkg::PH_HDR1))

endmodule
